// ----- rtl/kmedoids_swap_search_assert.svh -----
// assertion macros for the k-medoids swap search block
// no dependencies; included by the top level
`ifndef KMEDOIDS_SWAP_SEARCH_ASSERT_SVH
`define KMEDOIDS_SWAP_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define KSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kss: implication check failed");
`define KSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kss: next-cycle check failed");
`else
`define KSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define KSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/kss_pkg.sv -----
// shared constants, command codes and control structs for the swap search
// no dependencies
`default_nettype none
package kss_pkg;
   localparam int MAX_POINTS_DEF  = 1024;
   localparam int MAX_MEDOIDS_DEF = 16;
   localparam int COORD_BITS_DEF  = 16;

   localparam int K_W           = 5;
   localparam int SLOT_FIELD_W  = 4;
   localparam int INDEX_FIELD_W = 10;
   localparam int COST_FIELD_W  = 27;

   localparam logic [COST_FIELD_W-1:0] COST_MAX = '1;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_RUN  = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic load;
      logic set;
      logic slot_clr;
      logic slot_inc;
      logic j_clr;
      logic j_inc;
      logic eval_start;
      logic eval_trial;
      logic cost_init;
      logic swap_take;
      logic changed_clr;
      logic out_ld;
      logic err_ld;
   } kss_cmd_type;

   typedef struct packed {
      logic run_bad;
      logic med_bad;
      logic slot_at_k;
      logic slot_last;
      logic j_at_pc;
      logic j_is_keep;
      logic eval_busy;
      logic eval_done;
      logic cost_less;
      logic changed;
      logic out_free;
   } kss_stat_type;
endpackage
`default_nettype wire

// ----- rtl/kss_ctrl.sv -----
// control state machine of the swap search: sequences checks, cost passes and output
// depends on kss_pkg
`default_nettype none
module kss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_cmd,
   output logic                 req_stall,
   output kss_pkg::kss_cmd_type cmd,
   input  kss_pkg::kss_stat_type stat
);
   import kss_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CHECK = 9'b000000010,
      ST_INITW = 9'b000000100,
      ST_PASS  = 9'b000001000,
      ST_TRY   = 9'b000010000,
      ST_WAIT  = 9'b000100000,
      ST_OUTR  = 9'b001000000,
      ST_OUTL  = 9'b010000000,
      ST_ERR   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_LOAD: cmd.load = 1'b1;
                  CMD_SET:  cmd.set = 1'b1;
                  CMD_RUN: begin
                     cmd.slot_clr = 1'b1;
                     state_in     = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         // validate k, point count and every initial index
         ST_CHECK: begin
            if (stat.run_bad) begin
               state_in = ST_ERR;
            end else if (stat.slot_at_k) begin
               cmd.eval_start = 1'b1;
               state_in       = ST_INITW;
            end else if (stat.med_bad) begin
               state_in = ST_ERR;
            end else begin
               cmd.slot_inc = 1'b1;
            end
         end
         ST_INITW: begin
            if (stat.eval_done) begin
               cmd.cost_init = 1'b1;
               state_in      = ST_PASS;
            end
         end
         ST_PASS: begin
            cmd.changed_clr = 1'b1;
            cmd.slot_clr    = 1'b1;
            cmd.j_clr       = 1'b1;
            state_in        = ST_TRY;
         end
         // pick the next candidate for the current slot, or step to the next slot, or end the pass
         ST_TRY: begin
            if (stat.slot_at_k) begin
               if (stat.changed) begin
                  state_in = ST_PASS;
               end else begin
                  cmd.slot_clr = 1'b1;
                  state_in     = ST_OUTR;
               end
            end else if (stat.j_at_pc) begin
               cmd.slot_inc = 1'b1;
               cmd.j_clr    = 1'b1;
            end else if (stat.j_is_keep) begin
               cmd.j_inc = 1'b1;
            end else begin
               cmd.eval_start = 1'b1;
               cmd.eval_trial = 1'b1;
               state_in       = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (stat.eval_done) begin
               if (stat.cost_less) begin
                  cmd.swap_take = 1'b1;
                  cmd.j_clr     = 1'b1;
               end else begin
                  cmd.j_inc = 1'b1;
               end
               state_in = ST_TRY;
            end
         end
         ST_OUTR: state_in = ST_OUTL;
         ST_OUTL: begin
            if (stat.out_free) begin
               cmd.out_ld = 1'b1;
               if (stat.slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_inc = 1'b1;
                  state_in     = ST_OUTR;
               end
            end
         end
         ST_ERR: begin
            if (stat.out_free) begin
               cmd.err_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/kss_datapath.sv -----
// datapath of the swap search: point memories, medoid slots, cost engine, result register
// depends on kss_pkg
`default_nettype none
module kss_datapath #(
   parameter int MAX_POINTS  = kss_pkg::MAX_POINTS_DEF,
   parameter int MAX_MEDOIDS = kss_pkg::MAX_MEDOIDS_DEF,
   parameter int COORD_BITS  = kss_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kss_pkg::kss_cmd_type               cmd,
   output kss_pkg::kss_stat_type              stat,
   input  logic                               csr_wr_en,
   input  logic [kss_pkg::K_W-1:0]            csr_wr_data,
   input  logic                               req_first_point,
   input  logic signed [COORD_BITS-1:0]       req_point_x,
   input  logic signed [COORD_BITS-1:0]       req_point_y,
   input  logic [kss_pkg::SLOT_FIELD_W-1:0]   req_slot,
   input  logic [kss_pkg::INDEX_FIELD_W-1:0]  req_medoid_index,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [kss_pkg::SLOT_FIELD_W-1:0]   rsp_out_slot,
   output logic [kss_pkg::INDEX_FIELD_W-1:0]  rsp_out_index,
   output logic signed [COORD_BITS-1:0]       rsp_out_x,
   output logic signed [COORD_BITS-1:0]       rsp_out_y,
   output logic [kss_pkg::COST_FIELD_W-1:0]   rsp_total_cost,
   output logic                               rsp_last
);
   import kss_pkg::*;

   localparam int PIDX_W = $clog2(MAX_POINTS);
   localparam int PC_W   = PIDX_W + 1;
   localparam int SLOT_W = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1;
   localparam int SCNT_W = $clog2(MAX_MEDOIDS + 1);
   localparam int CW     = (SCNT_W > K_W) ? SCNT_W : K_W;
   localparam int MED_W  = (PIDX_W > INDEX_FIELD_W) ? PIDX_W : INDEX_FIELD_W;
   localparam int MW2    = (MED_W > PC_W) ? MED_W : PC_W;
   localparam int PCK    = (PC_W > K_W) ? PC_W : K_W;
   localparam int DIF_W  = COORD_BITS + 1;
   localparam int D_W    = COORD_BITS + 2;
   localparam int CST_W  = D_W + PIDX_W;
   localparam int XW     = (CST_W > COST_FIELD_W) ? CST_W : COST_FIELD_W;

   // configuration and counters
   logic [K_W-1:0]    k_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [SCNT_W-1:0] slot_ff;
   logic [PC_W-1:0]   j_ff;
   logic [CST_W-1:0]  cur_cost_ff;
   logic              changed_ff;

   // storage
   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
   logic [MED_W-1:0]      med_ff [MAX_MEDOIDS];

   // cost engine
   logic              ev_busy_ff;
   logic              ev_trial_ff;
   logic [PIDX_W-1:0] ev_p_ff;
   logic [SLOT_W-1:0] ev_s_ff;
   logic              ev_s_last;
   logic              ev_p_last;
   logic [SLOT_W-1:0] med_addr;
   logic [MED_W-1:0]  med_rd;
   logic [PIDX_W-1:0] addr_a;
   logic [PIDX_W-1:0] addr_b;
   logic [COORD_BITS-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic              v1_ff, first1_ff, lasts1_ff, end1_ff;
   logic              v2_ff, first2_ff, lasts2_ff, end2_ff;
   logic [DIF_W-1:0]  dx, dy, adx, ady;
   logic [D_W-1:0]    d_in, d_ff;
   logic [D_W-1:0]    best_ff, best_in;
   logic [CST_W-1:0]  ev_sum_ff;
   logic              ev_done_ff;
   logic [XW-1:0]     cost_wide;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_W'(1);
      end else if (csr_wr_en) begin
         k_ff <= csr_wr_data;
      end
   end

   // point memories: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req_first_point) begin
            x_mem[0] <= req_point_x;
            y_mem[0] <= req_point_y;
         end else if (pc_ff < PC_W'(MAX_POINTS)) begin
            x_mem[PIDX_W'(pc_ff)] <= req_point_x;
            y_mem[PIDX_W'(pc_ff)] <= req_point_y;
         end
      end
      xa_ff <= x_mem[addr_a];
      ya_ff <= y_mem[addr_a];
      xb_ff <= x_mem[addr_b];
      yb_ff <= y_mem[addr_b];
   end

   // point count
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (cmd.load) begin
         if (req_first_point) begin
            pc_ff <= PC_W'(1);
         end else if (pc_ff < PC_W'(MAX_POINTS)) begin
            pc_ff <= pc_ff + PC_W'(1);
         end
      end
   end

   // medoid slots, written by set items and by taken swaps
   always_ff @(posedge clock) begin
      if (cmd.set && (CW'(req_slot) < CW'(MAX_MEDOIDS))) begin
         med_ff[SLOT_W'(req_slot)] <= MED_W'(req_medoid_index);
      end else if (cmd.swap_take) begin
         med_ff[SLOT_W'(slot_ff)] <= MED_W'(j_ff);
      end
   end

   // slot and candidate counters, running cost, pass flag
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         j_ff        <= '0;
         cur_cost_ff <= '0;
         changed_ff  <= 1'b0;
      end else begin
         if (cmd.slot_clr) begin
            slot_ff <= '0;
         end else if (cmd.slot_inc) begin
            slot_ff <= slot_ff + SCNT_W'(1);
         end
         if (cmd.j_clr) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + PC_W'(1);
         end
         if (cmd.cost_init || cmd.swap_take) begin
            cur_cost_ff <= ev_sum_ff;
         end
         if (cmd.swap_take) begin
            changed_ff <= 1'b1;
         end else if (cmd.changed_clr) begin
            changed_ff <= 1'b0;
         end
      end
   end

   // shared medoid read and point addresses
   always_comb begin
      med_addr = ev_busy_ff ? ev_s_ff : SLOT_W'(slot_ff);
      med_rd   = med_ff[med_addr];
      addr_a   = ev_p_ff;
      if (ev_busy_ff && ev_trial_ff && (ev_s_ff == SLOT_W'(slot_ff))) begin
         addr_b = PIDX_W'(j_ff);
      end else begin
         addr_b = PIDX_W'(med_rd);
      end
      ev_s_last = ((CW'(ev_s_ff) + CW'(1)) == CW'(k_ff));
      ev_p_last = ((PC_W'(ev_p_ff) + PC_W'(1)) == pc_ff);
   end

   // cost engine issue: point outer, slot inner, one pair a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_busy_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         ev_done_ff <= 1'b0;
      end else begin
         if (cmd.eval_start) begin
            ev_busy_ff <= 1'b1;
         end else if (ev_busy_ff && ev_s_last && ev_p_last) begin
            ev_busy_ff <= 1'b0;
         end
         v1_ff      <= ev_busy_ff;
         v2_ff      <= v1_ff;
         ev_done_ff <= v2_ff && end2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_start) begin
         ev_trial_ff <= cmd.eval_trial;
         ev_p_ff     <= '0;
         ev_s_ff     <= '0;
      end else if (ev_busy_ff) begin
         if (ev_s_last) begin
            ev_s_ff <= '0;
            ev_p_ff <= ev_p_ff + PIDX_W'(1);
         end else begin
            ev_s_ff <= ev_s_ff + SLOT_W'(1);
         end
      end
      first1_ff <= (ev_s_ff == '0);
      lasts1_ff <= ev_s_last;
      end1_ff   <= ev_s_last && ev_p_last;
      first2_ff <= first1_ff;
      lasts2_ff <= lasts1_ff;
      end2_ff   <= end1_ff;
      d_ff      <= d_in;
   end

   // manhattan distance of the read pair
   always_comb begin
      dx   = {xa_ff[COORD_BITS-1], xa_ff} - {xb_ff[COORD_BITS-1], xb_ff};
      dy   = {ya_ff[COORD_BITS-1], ya_ff} - {yb_ff[COORD_BITS-1], yb_ff};
      adx  = dx[DIF_W-1] ? (~dx + DIF_W'(1)) : dx;
      ady  = dy[DIF_W-1] ? (~dy + DIF_W'(1)) : dy;
      d_in = D_W'(adx) + D_W'(ady);
   end

   // nearest medoid per point, summed over points
   assign best_in = (first2_ff || (d_ff < best_ff)) ? d_ff : best_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval_start) begin
         ev_sum_ff <= '0;
      end else if (v2_ff && lasts2_ff) begin
         ev_sum_ff <= ev_sum_ff + CST_W'(best_in);
      end
      if (v2_ff) begin
         best_ff <= best_in;
      end
   end

   // result register
   assign cost_wide = XW'(cur_cost_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_ld || cmd.err_ld) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_ld) begin
         rsp_status     <= STATUS_BAD;
         rsp_out_slot   <= '0;
         rsp_out_index  <= '0;
         rsp_out_x      <= '0;
         rsp_out_y      <= '0;
         rsp_total_cost <= '0;
         rsp_last       <= 1'b1;
      end else if (cmd.out_ld) begin
         rsp_status     <= STATUS_OK;
         rsp_out_slot   <= SLOT_FIELD_W'(slot_ff);
         rsp_out_index  <= INDEX_FIELD_W'(med_rd);
         rsp_out_x      <= xb_ff;
         rsp_out_y      <= yb_ff;
         rsp_total_cost <= (cost_wide > XW'(COST_MAX)) ? COST_MAX
                                                        : COST_FIELD_W'(cost_wide);
         rsp_last       <= stat.slot_last;
      end
   end

   // status toward the controller
   always_comb begin
      stat.run_bad   = (k_ff == '0) || (CW'(k_ff) > CW'(MAX_MEDOIDS)) ||
                       (PCK'(pc_ff) <= PCK'(k_ff));
      stat.med_bad   = (MW2'(med_rd) >= MW2'(pc_ff));
      stat.slot_at_k = (CW'(slot_ff) == CW'(k_ff));
      stat.slot_last = ((CW'(slot_ff) + CW'(1)) == CW'(k_ff));
      stat.j_at_pc   = (j_ff == pc_ff);
      stat.j_is_keep = (MW2'(j_ff) == MW2'(med_rd));
      stat.eval_busy = ev_busy_ff || v1_ff || v2_ff;
      stat.eval_done = ev_done_ff;
      stat.cost_less = (ev_sum_ff < cur_cost_ff);
      stat.changed   = changed_ff;
      stat.out_free  = !rsp_valid || !rsp_stall;
   end
endmodule
`default_nettype wire

// ----- rtl/kmedoids_swap_search.sv -----
// Load and set items are taken one per cycle while no run is active and give no result.
// A run item performs cost evaluations over P points and k medoids:
// one initial evaluation, then one per candidate tried, over passes until no swap.
// Results come one per slot (OUTR, OUTL); the evaluator reads one point pair a cycle.
// Reset (synchronous, active high) clears k to 1, point count, cost and control state;
// point and medoid storage hold no reset value.
`default_nettype none
`include "kmedoids_swap_search_assert.svh"
module kmedoids_swap_search #(
   parameter int MAX_POINTS  = kss_pkg::MAX_POINTS_DEF,
   parameter int MAX_MEDOIDS = kss_pkg::MAX_MEDOIDS_DEF,
   parameter int COORD_BITS  = kss_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [kss_pkg::K_W-1:0]            csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic                               req_first_point,
   input  logic signed [COORD_BITS-1:0]       req_point_x,
   input  logic signed [COORD_BITS-1:0]       req_point_y,
   input  logic [kss_pkg::SLOT_FIELD_W-1:0]   req_slot,
   input  logic [kss_pkg::INDEX_FIELD_W-1:0]  req_medoid_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status,
   output logic [kss_pkg::SLOT_FIELD_W-1:0]   rsp_out_slot,
   output logic [kss_pkg::INDEX_FIELD_W-1:0]  rsp_out_index,
   output logic signed [COORD_BITS-1:0]       rsp_out_x,
   output logic signed [COORD_BITS-1:0]       rsp_out_y,
   output logic [kss_pkg::COST_FIELD_W-1:0]   rsp_total_cost,
   output logic                               rsp_last
);
   import kss_pkg::*;

   kss_cmd_type  cmd;
   kss_stat_type stat;

   kss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   kss_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_MEDOIDS (MAX_MEDOIDS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_first_point  (req_first_point),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_slot         (req_slot),
      .req_medoid_index (req_medoid_index),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_last         (rsp_last)
   );

   // a waiting result is never overwritten
   `KSS_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_ld || cmd.err_ld, stat.out_free)
   // items are only taken while the cost engine is quiet
   `KSS_ASSERT_IMP(a_idle_engine, clock, reset, !req_stall, !stat.eval_busy)
   // a taken swap marks the pass as changed
   `KSS_ASSERT_NXT(a_swap_marks, clock, reset, cmd.swap_take, stat.changed)
endmodule
`default_nettype wire
